>>> sv/two_link_arm_collision_check_top_macros.svh
`ifndef TWO_LINK_ARM_COLLISION_CHECK_TOP_MACROS_SVH
`define TWO_LINK_ARM_COLLISION_CHECK_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLACC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TLACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/tlacc_pkg.sv
package tlacc_pkg;

  localparam int CORDIC_STAGES = 14;
  localparam int SC_LAT = CORDIC_STAGES + 3;

  typedef logic signed [16:0] ang_t;
  typedef logic signed [17:0] trig_t;
  typedef logic [2:0] cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;
  } in_req_t;

  typedef struct packed {
    logic        feasible;
    logic [10:0] violation_mask;
  } out_res_t;

  localparam cfg_idx_t CFG_LINK1 = 3'd0;
  localparam cfg_idx_t CFG_LINK2 = 3'd1;
  localparam cfg_idx_t CFG_OBS_AX = 3'd2;
  localparam cfg_idx_t CFG_OBS_AY = 3'd3;
  localparam cfg_idx_t CFG_OBS_BX = 3'd4;
  localparam cfg_idx_t CFG_OBS_BY = 3'd5;
  localparam cfg_idx_t CFG_CLEAR = 3'd6;
  localparam cfg_idx_t CFG_ELBOW = 3'd7;

  localparam logic signed [35:0] W_PI1 = 36'sd3373259426;
  localparam logic signed [35:0] W_PI3 = 36'sd10119778278;
  localparam logic signed [35:0] W_PI5 = 36'sd16866297130;
  localparam logic signed [35:0] W_TWO_PI = 36'sd6746518852;
  localparam logic signed [32:0] Z_PI = 33'sd3373259426;
  localparam logic signed [32:0] Z_HALF_PI = 33'sd1686629713;
  localparam logic signed [33:0] X_GAIN = 34'sd652032874;
  localparam logic signed [34:0] FLOOR_OFFSET = 35'sd26843546;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd843314856;
      5'd1: v = 32'd497837829;
      5'd2: v = 32'd263043836;
      5'd3: v = 32'd133525158;
      5'd4: v = 32'd67021686;
      5'd5: v = 32'd33543515;
      5'd6: v = 32'd16775850;
      5'd7: v = 32'd8388437;
      5'd8: v = 32'd4194282;
      5'd9: v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/tlacc_sincos.sv
module tlacc_sincos (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  tlacc_pkg::ang_t  angle,
  output logic          out_vld,
  output tlacc_pkg::trig_t sin_q,
  output tlacc_pkg::trig_t cos_q
);
  import tlacc_pkg::*;

  logic signed [35:0] zw;
  logic signed [35:0] zred;
  logic signed [32:0] z1_r;
  logic               v1_r;
  logic signed [32:0] zf_nxt;
  logic               flip_nxt;
  logic signed [32:0] z2_r;
  logic               flip2_r;
  logic               v2_r;

  logic signed [33:0] cx_r [1:CORDIC_STAGES];
  logic signed [33:0] cy_r [1:CORDIC_STAGES];
  logic signed [32:0] cz_r [1:CORDIC_STAGES];
  logic               cf_r [1:CORDIC_STAGES];
  logic               cv_r [1:CORDIC_STAGES];

  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] xr;
  logic signed [33:0] yr;
  trig_t              sin_r;
  trig_t              cos_r;
  logic               vo_r;

  assign zw = {angle[16], angle, 18'b0};

  always_comb begin
    if (zw >= W_PI5) begin
      zred = zw - 36'(3) * W_TWO_PI;
    end else if (zw >= W_PI3) begin
      zred = zw - 36'(2) * W_TWO_PI;
    end else if (zw >= W_PI1) begin
      zred = zw - W_TWO_PI;
    end else if (zw < -W_PI5) begin
      zred = zw + 36'(3) * W_TWO_PI;
    end else if (zw < -W_PI3) begin
      zred = zw + 36'(2) * W_TWO_PI;
    end else if (zw < -W_PI1) begin
      zred = zw + W_TWO_PI;
    end else begin
      zred = zw;
    end
  end

  always_comb begin
    if (z1_r > Z_HALF_PI) begin
      zf_nxt = z1_r - Z_PI;
      flip_nxt = 1'b1;
    end else if (z1_r < -Z_HALF_PI) begin
      zf_nxt = z1_r + Z_PI;
      flip_nxt = 1'b1;
    end else begin
      zf_nxt = z1_r;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    z1_r <= zred[32:0];
    z2_r <= zf_nxt;
    flip2_r <= flip_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [33:0] xi;
    logic signed [33:0] yi;
    logic signed [32:0] zi;
    logic               fi;
    logic               vi;
    logic signed [32:0] at;

    if (i == 0) begin : g_first
      assign xi = X_GAIN;
      assign yi = '0;
      assign zi = z2_r;
      assign fi = flip2_r;
      assign vi = v2_r;
    end else begin : g_next
      assign xi = cx_r[i];
      assign yi = cy_r[i];
      assign zi = cz_r[i];
      assign fi = cf_r[i];
      assign vi = cv_r[i];
    end

    assign at = $signed({1'b0, atan_q30(5'(i))});

    always_ff @(posedge clk) begin
      if (!zi[32]) begin
        cx_r[i+1] <= xi - (yi >>> i);
        cy_r[i+1] <= yi + (xi >>> i);
        cz_r[i+1] <= zi - at;
      end else begin
        cx_r[i+1] <= xi + (yi >>> i);
        cy_r[i+1] <= yi - (xi >>> i);
        cz_r[i+1] <= zi + at;
      end
      cf_r[i+1] <= fi;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else begin
        cv_r[i+1] <= vi;
      end
    end
  end

  assign xf = cf_r[CORDIC_STAGES] ? -cx_r[CORDIC_STAGES] : cx_r[CORDIC_STAGES];
  assign yf = cf_r[CORDIC_STAGES] ? -cy_r[CORDIC_STAGES] : cy_r[CORDIC_STAGES];
  assign xr = xf + 34'sd32768;
  assign yr = yf + 34'sd32768;

  always_ff @(posedge clk) begin
    sin_r <= yr[33:16];
    cos_r <= xr[33:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= cv_r[CORDIC_STAGES];
    end
  end

  assign out_vld = vo_r;
  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

>>> sv/two_link_arm_collision_check_top.sv
// Pose feasibility check for a planar two-link arm.
// A request carries the shoulder and elbow joint angles (Q3.12 radians).
// It is accepted at a rising edge where start is high and busy is low.
// busy is never raised, so a new request can be taken on every cycle.
// Each request yields exactly one result, shown on out_data for one cycle
// with out_valid high: feasible and an 11-bit violation mask.
// The result is registered and is taken at the edge after it is driven.
// The path is one input register loaded at the accepting edge, the
// sine/cosine pipeline (two reduction stages, one stage per CORDIC
// iteration, one rounding stage) and six geometry stages (products,
// sample points, offsets, partial squares, squares, distance compare).
// Throughput is one request per cycle; results leave in request order.
// The receiver cannot stall, so the pipeline never holds.
// Registers are written through cfg_we, cfg_addr and cfg_wdata and must
// only change while no request is in flight.
// Synchronous reset clears all valid bits and loads the default registers.
`include "two_link_arm_collision_check_top_macros.svh"

module two_link_arm_collision_check_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tlacc_pkg::in_req_t in_data,
  output logic               out_valid,
  output tlacc_pkg::out_res_t out_data,
  input  logic               cfg_we,
  input  tlacc_pkg::cfg_idx_t cfg_addr,
  input  logic [31:0]        cfg_wdata
);
  import tlacc_pkg::*;

  logic [14:0]        link1_r;
  logic [14:0]        link2_r;
  logic signed [15:0] obs_ax_r;
  logic signed [15:0] obs_ay_r;
  logic signed [15:0] obs_bx_r;
  logic signed [15:0] obs_by_r;
  logic [31:0]        clear_r;
  logic [14:0]        elbow_r;

  logic               v0_r;
  logic signed [15:0] t1_r;
  logic signed [15:0] t2_r;
  ang_t               a1;
  ang_t               a2;
  logic [16:0]        t2e;
  logic [16:0]        t2_mag;
  logic               elb_bad;
  logic               elb_dly_r [SC_LAT];

  logic  sc1_vld;
  logic  sc2_vld;
  trig_t s1;
  trig_t c1;
  trig_t s12;
  trig_t c12;

  logic signed [33:0] l1c1_r;
  logic signed [33:0] l1s1_r;
  logic signed [33:0] l2c12_r;
  logic signed [33:0] l2s12_r;
  logic               v1_r;
  logic               e1_r;

  logic signed [34:0] h1;
  logic signed [34:0] h2;
  logic signed [32:0] px_nxt [4];
  logic signed [32:0] py_nxt [4];
  logic signed [32:0] px_r [4];
  logic signed [32:0] py_r [4];
  logic [2:0]         m2_r;
  logic               v2_r;

  logic [31:0] mag_nxt [16];
  logic [31:0] mag_r [16];
  logic [2:0]  m3_r;
  logic        v3_r;

  logic [31:0] hh_r [16];
  logic [31:0] hl_r [16];
  logic [31:0] ll_r [16];
  logic [2:0]  m4_r;
  logic        v4_r;

  logic [63:0] sq_r [16];
  logic [2:0]  m5_r;
  logic        v5_r;

  logic [63:0] clr;
  logic [7:0]  obs_bad;
  logic [10:0] mask_nxt;
  out_res_t    out_r;
  logic        out_valid_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link1_r <= 15'd8192;
      link2_r <= 15'd6554;
      obs_ax_r <= -16'sd9830;
      obs_ay_r <= 16'sd11469;
      obs_bx_r <= 16'sd9830;
      obs_by_r <= 16'sd11469;
      clear_r <= 32'd16508781;
      elbow_r <= 15'd6431;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LINK1: link1_r <= cfg_wdata[14:0];
        CFG_LINK2: link2_r <= cfg_wdata[14:0];
        CFG_OBS_AX: obs_ax_r <= $signed(cfg_wdata[15:0]);
        CFG_OBS_AY: obs_ay_r <= $signed(cfg_wdata[15:0]);
        CFG_OBS_BX: obs_bx_r <= $signed(cfg_wdata[15:0]);
        CFG_OBS_BY: obs_by_r <= $signed(cfg_wdata[15:0]);
        CFG_CLEAR: clear_r <= cfg_wdata;
        CFG_ELBOW: elbow_r <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    t1_r <= in_data.shoulder_angle;
    t2_r <= in_data.elbow_angle;
  end

  assign a1 = {t1_r[15], t1_r};
  assign a2 = a1 + $signed({t2_r[15], t2_r});
  assign t2e = {t2_r[15], t2_r};
  assign t2_mag = t2e[16] ? (17'd0 - t2e) : t2e;
  assign elb_bad = !(t2_mag < {2'b00, elbow_r});

  always_ff @(posedge clk) begin
    elb_dly_r[0] <= elb_bad;
    for (int j = 1; j < SC_LAT; j++) begin
      elb_dly_r[j] <= elb_dly_r[j-1];
    end
  end

  tlacc_sincos u_sc1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v0_r),
    .angle   (a1),
    .out_vld (sc1_vld),
    .sin_q   (s1),
    .cos_q   (c1)
  );

  tlacc_sincos u_sc2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v0_r),
    .angle   (a2),
    .out_vld (sc2_vld),
    .sin_q   (s12),
    .cos_q   (c12)
  );

  always_ff @(posedge clk) begin
    l1c1_r <= $signed({1'b0, link1_r}) * c1;
    l1s1_r <= $signed({1'b0, link1_r}) * s1;
    l2c12_r <= $signed({1'b0, link2_r}) * c12;
    l2s12_r <= $signed({1'b0, link2_r}) * s12;
    e1_r <= elb_dly_r[SC_LAT-1];
  end

  assign h1 = 35'(l1s1_r) + FLOOR_OFFSET;
  assign h2 = 35'(l1s1_r) + 35'(l2s12_r) + FLOOR_OFFSET;

  always_comb begin
    logic signed [37:0] sx;
    logic signed [37:0] sy;
    for (int k = 0; k < 4; k++) begin
      sx = (38'(l1c1_r) <<< 3) + 38'(l2c12_r) * 38'(2 * k + 1) + 38'sd4;
      sy = (38'(l1s1_r) <<< 3) + 38'(l2s12_r) * 38'(2 * k + 1) + 38'sd4;
      px_nxt[k] = sx[35:3];
      py_nxt[k] = sy[35:3];
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
    m2_r <= {e1_r, !(h2 > 35'sd0), !(h1 > 35'sd0)};
  end

  always_comb begin
    logic signed [33:0] ox;
    logic signed [33:0] oy;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    for (int ob = 0; ob < 2; ob++) begin
      ox = (ob == 0) ? (34'(obs_ax_r) <<< 14) : (34'(obs_bx_r) <<< 14);
      oy = (ob == 0) ? (34'(obs_ay_r) <<< 14) : (34'(obs_by_r) <<< 14);
      for (int k = 0; k < 4; k++) begin
        dx = 34'(px_r[k]) - ox;
        dy = 34'(py_r[k]) - oy;
        mag_nxt[ob * 8 + k * 2] = dx[33] ? 32'(-dx) : dx[31:0];
        mag_nxt[ob * 8 + k * 2 + 1] = dy[33] ? 32'(-dy) : dy[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    m3_r <= m2_r;
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < 16; n++) begin
      hh_r[n] <= mag_r[n][31:16] * mag_r[n][31:16];
      hl_r[n] <= mag_r[n][31:16] * mag_r[n][15:0];
      ll_r[n] <= mag_r[n][15:0] * mag_r[n][15:0];
    end
    m4_r <= m3_r;
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < 16; n++) begin
      sq_r[n] <= {hh_r[n], 32'b0} + (64'(hl_r[n]) << 17) + 64'(ll_r[n]);
    end
    m5_r <= m4_r;
  end

  assign clr = {4'b0, clear_r, 28'b0};

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      obs_bad[p] = !((sq_r[p * 2] + sq_r[p * 2 + 1]) > clr);
    end
  end

  assign mask_nxt = {m5_r[2], obs_bad, m5_r[1:0]};

  always_ff @(posedge clk) begin
    out_r.violation_mask <= mask_nxt;
    out_r.feasible <= (mask_nxt == 11'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= sc1_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `TLACC_ASSERT_NOW(a_lanes_aligned, 1'b1, sc1_vld == sc2_vld, "sine/cosine lanes out of step")
  `TLACC_ASSERT_NOW(a_feasible_mask, out_valid, out_data.feasible == (out_data.violation_mask == 11'd0), "feasible disagrees with mask")
  `TLACC_ASSERT_NEXT(a_geom_latency, v2_r, v3_r, "request lost in geometry stages")

endmodule
